// ===== design/cbb_pkg.sv =====
// Shared types and constants for the clipped bitmap blit core.
`timescale 1ns / 1ps
`default_nettype none
package cbb_pkg;

  localparam int COORD_BITS = 16;
  localparam int FIELD_BITS = 16;
  localparam int DIM_BITS   = 12;
  localparam int SUM_BITS   = COORD_BITS + 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [FIELD_BITS-1:0] CMD_COLUMN = 16'h002A;
  localparam logic [FIELD_BITS-1:0] CMD_ROW    = 16'h002B;
  localparam logic [FIELD_BITS-1:0] CMD_MEMORY = 16'h002C;
  localparam logic [FIELD_BITS-1:0] LOW_BYTE   = 16'h00FF;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [0:0] {
    KIND_HEADER = 1'b0,
    KIND_PIXEL  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
  } panel_t;

  typedef struct packed {
    kind_e                 kind;
    logic [DIM_BITS-1:0]   x0;
    logic [DIM_BITS-1:0]   x1;
    logic [DIM_BITS-1:0]   y0;
    logic [DIM_BITS-1:0]   y1;
    logic [FIELD_BITS-1:0] pixel;
  } job_t;

endpackage
`default_nettype wire

// ===== design/cbb_front.sv =====
// Front end: accepts items, clips rectangles, tracks pixel positions, queues jobs.
`timescale 1ns / 1ps
`default_nettype none
module cbb_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          in_mode_i,
  input  wire  [cbb_pkg::FIELD_BITS-1:0] in_x_i,
  input  wire  [cbb_pkg::FIELD_BITS-1:0] in_y_i,
  input  wire  [cbb_pkg::FIELD_BITS-1:0] in_w_i,
  input  wire  [cbb_pkg::FIELD_BITS-1:0] in_h_i,
  input  wire  [cbb_pkg::FIELD_BITS-1:0] in_pixel_i,
  input  cbb_pkg::panel_t              panel_i,
  input  wire                          full_i,
  output logic                         push_o,
  output cbb_pkg::job_t                push_job_o
);
  import cbb_pkg::*;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic signed [SUM_BITS-1:0] v,
                                                    input logic [DIM_BITS-1:0] size);
    logic signed [SUM_BITS-1:0] size_s;
    size_s = SUM_BITS'(size);
    if (v < 0) begin
      return '0;
    end else if (v >= size_s) begin
      return size - DIM_BITS'(1);
    end else begin
      return v[DIM_BITS-1:0];
    end
  endfunction

  localparam logic signed [SUM_BITS-1:0] ONE = 1;

  logic                       accept;
  logic signed [SUM_BITS-1:0] xs, ys, ws, hs, x1s, y1s, wd_s, ht_s;
  logic                       reject, on_panel, col_wrap, row_wrap;
  logic [COORD_BITS:0]        col_inc, row_inc;

  logic                       session_q, session_d;
  logic signed [SUM_BITS-1:0] origin_x_q, origin_x_d;
  logic signed [SUM_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0]      span_cols_q, span_cols_d, span_rows_q, span_rows_d;
  logic [COORD_BITS-1:0]      col_q, col_d, row_q, row_d;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  assign xs   = SUM_BITS'(signed'(in_x_i[COORD_BITS-1:0]));
  assign ys   = SUM_BITS'(signed'(in_y_i[COORD_BITS-1:0]));
  assign ws   = SUM_BITS'(signed'(in_w_i[COORD_BITS-1:0]));
  assign hs   = SUM_BITS'(signed'(in_h_i[COORD_BITS-1:0]));
  assign wd_s = SUM_BITS'(panel_i.width);
  assign ht_s = SUM_BITS'(panel_i.height);
  assign x1s  = xs + ws - ONE;
  assign y1s  = ys + hs - ONE;

  assign reject = (panel_i.width == '0) || (panel_i.height == '0) || (xs >= wd_s)
                  || (ys >= ht_s);
  assign on_panel = (cur_x_q >= 0) && (cur_x_q < wd_s) && (cur_y_q >= 0) && (cur_y_q < ht_s);

  assign col_inc  = (COORD_BITS + 1)'(col_q) + (COORD_BITS + 1)'(1);
  assign row_inc  = (COORD_BITS + 1)'(row_q) + (COORD_BITS + 1)'(1);
  assign col_wrap = (col_inc == {1'b0, span_cols_q});
  assign row_wrap = (row_inc == {1'b0, span_rows_q});

  always_comb begin
    push_o           = 1'b0;
    push_job_o.kind  = in_mode_i ? KIND_PIXEL : KIND_HEADER;
    push_job_o.x0    = clamp_dim(xs, panel_i.width);
    push_job_o.x1    = clamp_dim(x1s, panel_i.width);
    push_job_o.y0    = clamp_dim(ys, panel_i.height);
    push_job_o.y1    = clamp_dim(y1s, panel_i.height);
    push_job_o.pixel = in_pixel_i;

    session_d   = session_q;
    origin_x_d  = origin_x_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    span_cols_d = span_cols_q;
    span_rows_d = span_rows_q;
    col_d       = col_q;
    row_d       = row_q;

    if (accept) begin
      if (!in_mode_i) begin
        session_d = 1'b0;
        if (!reject) begin
          push_o      = 1'b1;
          session_d   = (ws > 0) && (hs > 0);
          origin_x_d  = xs;
          cur_x_d     = xs;
          cur_y_d     = ys;
          span_cols_d = ws[COORD_BITS-1:0];
          span_rows_d = hs[COORD_BITS-1:0];
          col_d       = '0;
          row_d       = '0;
        end
      end else if (session_q) begin
        push_o = on_panel;
        if (col_wrap) begin
          col_d   = '0;
          cur_x_d = origin_x_q;
          if (row_wrap) begin
            row_d     = '0;
            session_d = 1'b0;
          end else begin
            row_d   = row_inc[COORD_BITS-1:0];
            cur_y_d = cur_y_q + ONE;
          end
        end else begin
          col_d   = col_inc[COORD_BITS-1:0];
          cur_x_d = cur_x_q + ONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_q   <= 1'b0;
      origin_x_q  <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      span_cols_q <= '0;
      span_rows_q <= '0;
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      session_q   <= session_d;
      origin_x_q  <= origin_x_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      span_cols_q <= span_cols_d;
      span_rows_q <= span_rows_d;
      col_q       <= col_d;
      row_q       <= row_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/cbb_queue.sv =====
// Small job queue between the front end and the bus sequencer.
`timescale 1ns / 1ps
`default_nettype none
module cbb_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  cbb_pkg::job_t  push_job_i,
  output logic           full_o,
  input  wire            pop_i,
  output cbb_pkg::job_t  head_o,
  output logic           empty_o
);
  import cbb_pkg::*;

  job_t                  slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_q, rd_q;
  logic [QUEUE_AW:0]     count_q;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QUEUE_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QUEUE_AW + 1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/cbb_back.sv =====
// Back end: expands queued jobs into panel bus beats behind an output register.
`timescale 1ns / 1ps
`default_nettype none
module cbb_back (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  cbb_pkg::job_t                  head_i,
  input  wire                            empty_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic                           out_is_command_o,
  output logic [cbb_pkg::FIELD_BITS-1:0] out_bus_value_o,
  output logic                           out_last_o
);
  import cbb_pkg::*;

  typedef enum logic [3:0] {
    B_CMD_COL = 4'd0,
    B_X0_HI   = 4'd1,
    B_X0_LO   = 4'd2,
    B_X1_HI   = 4'd3,
    B_X1_LO   = 4'd4,
    B_CMD_ROW = 4'd5,
    B_Y0_HI   = 4'd6,
    B_Y0_LO   = 4'd7,
    B_Y1_HI   = 4'd8,
    B_Y1_LO   = 4'd9,
    B_CMD_MEM = 4'd10
  } beat_e;

  beat_e                 beat_q;
  logic                  load, emit;
  logic                  is_cmd, is_last;
  logic [FIELD_BITS-1:0] value;

  logic                  valid_q, cmd_q, last_q;
  logic [FIELD_BITS-1:0] value_q;

  assign load  = !valid_q || !out_stall_i;
  assign emit  = load && !empty_i;
  assign pop_o = emit && is_last;

  always_comb begin
    is_cmd  = 1'b0;
    is_last = 1'b0;
    value   = head_i.pixel;
    if (head_i.kind == KIND_PIXEL) begin
      is_last = 1'b1;
    end else begin
      unique case (beat_q)
        B_CMD_COL: begin is_cmd = 1'b1; value = CMD_COLUMN; end
        B_X0_HI:   value = FIELD_BITS'(head_i.x0 >> 8);
        B_X0_LO:   value = FIELD_BITS'(head_i.x0) & LOW_BYTE;
        B_X1_HI:   value = FIELD_BITS'(head_i.x1 >> 8);
        B_X1_LO:   value = FIELD_BITS'(head_i.x1) & LOW_BYTE;
        B_CMD_ROW: begin is_cmd = 1'b1; value = CMD_ROW; end
        B_Y0_HI:   value = FIELD_BITS'(head_i.y0 >> 8);
        B_Y0_LO:   value = FIELD_BITS'(head_i.y0) & LOW_BYTE;
        B_Y1_HI:   value = FIELD_BITS'(head_i.y1 >> 8);
        B_Y1_LO:   value = FIELD_BITS'(head_i.y1) & LOW_BYTE;
        B_CMD_MEM: begin is_cmd = 1'b1; is_last = 1'b1; value = CMD_MEMORY; end
        default:   begin is_last = 1'b1; end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q  <= B_CMD_COL;
      valid_q <= 1'b0;
      cmd_q   <= 1'b0;
      last_q  <= 1'b0;
      value_q <= '0;
    end else if (load) begin
      valid_q <= emit;
      if (emit) begin
        cmd_q   <= is_cmd;
        last_q  <= is_last;
        value_q <= value;
        beat_q  <= is_last ? B_CMD_COL : beat_e'(beat_q + 4'd1);
      end
    end
  end

  assign out_valid_o      = valid_q;
  assign out_is_command_o = cmd_q;
  assign out_bus_value_o  = value_q;
  assign out_last_o       = last_q;

endmodule
`default_nettype wire

// ===== design/clipped_bitmap_blit_to_panel_core.sv =====
// Top level of the clipped bitmap blit core: panel size registers and the pipeline.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   mode, x, y, w, h, pixel
//   out      output     out_valid_o / out_stall_i is_command, bus_value, last
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_wdata_i
//
// One input beat per cycle while the job queue has room; a pixel gives at most one
// output beat, an unrejected start eleven, sent one per cycle by the back-end
// sequencer when not stalled; jobs pass the queue, then the output register.
// Reset is asynchronous and active low; panel size resets to 320 by 480.
// Output stall fills the four-entry queue, after which in_stall_o rises.
`timescale 1ns / 1ps
`default_nettype none
module clipped_bitmap_blit_to_panel_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire                            in_mode_i,
  input  wire  [cbb_pkg::FIELD_BITS-1:0] in_x_i,
  input  wire  [cbb_pkg::FIELD_BITS-1:0] in_y_i,
  input  wire  [cbb_pkg::FIELD_BITS-1:0] in_w_i,
  input  wire  [cbb_pkg::FIELD_BITS-1:0] in_h_i,
  input  wire  [cbb_pkg::FIELD_BITS-1:0] in_pixel_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic                           out_is_command_o,
  output logic [cbb_pkg::FIELD_BITS-1:0] out_bus_value_o,
  output logic                           out_last_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire                            cfg_index_i,
  input  wire  [cbb_pkg::DIM_BITS-1:0]   cfg_wdata_i
);
  import cbb_pkg::*;

  panel_t panel_q;
  logic   push, pop, full, empty;
  job_t   push_job, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_q.width  <= DIM_BITS'(320);
      panel_q.height <= DIM_BITS'(480);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_WIDTH:  panel_q.width  <= cfg_wdata_i;
        REG_HEIGHT: panel_q.height <= cfg_wdata_i;
        default:    panel_q        <= panel_q;
      endcase
    end
  end

  cbb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_mode_i  (in_mode_i),
    .in_x_i     (in_x_i),
    .in_y_i     (in_y_i),
    .in_w_i     (in_w_i),
    .in_h_i     (in_h_i),
    .in_pixel_i (in_pixel_i),
    .panel_i    (panel_q),
    .full_i     (full),
    .push_o     (push),
    .push_job_o (push_job)
  );

  cbb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  cbb_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_is_command_o (out_is_command_o),
    .out_bus_value_o  (out_bus_value_o),
    .out_last_o       (out_last_o)
  );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the clipped bitmap blit core: directed table, random bursts, predictor check.
`timescale 1ns / 1ps
module tb;
  import cbb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_HDR,
    CHK_PIX
  } chk_e;

  typedef struct packed {
    kind_e                 mode;
    logic [FIELD_BITS-1:0] x;
    logic [FIELD_BITS-1:0] y;
    logic [FIELD_BITS-1:0] w;
    logic [FIELD_BITS-1:0] h;
    logic [FIELD_BITS-1:0] pixel;
  } in_beat_t;

  typedef struct packed {
    logic                  is_command;
    logic [FIELD_BITS-1:0] bus_value;
    logic                  last;
  } write_t;

  typedef struct packed {
    kind_e                 mode;
    logic [FIELD_BITS-1:0] x;
    logic [FIELD_BITS-1:0] y;
    logic [FIELD_BITS-1:0] w;
    logic [FIELD_BITS-1:0] h;
    logic [FIELD_BITS-1:0] pixel;
    chk_e                  chk;
    logic [DIM_BITS-1:0]   c0;
    logic [DIM_BITS-1:0]   c1;
    logic [DIM_BITS-1:0]   r0;
    logic [DIM_BITS-1:0]   r1;
  } dir_row_t;

  // Panel 320x480 after reset.
  localparam dir_row_t DIR_ROWS [0:24] = '{
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, CHK_NONE, 0, 0, 0, 0},
    '{KIND_HEADER, 16'h0000, 16'h0000, 16'h0002, 16'h0002, 16'h0000, CHK_HDR, 0, 1, 0, 1},
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, CHK_PIX, 0, 0, 0, 0},
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, CHK_PIX, 0, 0, 0, 0},
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hA5A5, CHK_PIX, 0, 0, 0, 0},
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h5A5A, CHK_PIX, 0, 0, 0, 0},
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1234, CHK_NONE, 0, 0, 0, 0},
    '{KIND_HEADER, 16'hFFFF, 16'hFFFF, 16'h0002, 16'h0002, 16'h0000, CHK_HDR, 0, 0, 0, 0},
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1111, CHK_NONE, 0, 0, 0, 0},
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h2222, CHK_NONE, 0, 0, 0, 0},
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h3333, CHK_NONE, 0, 0, 0, 0},
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4444, CHK_PIX, 0, 0, 0, 0},
    '{KIND_HEADER, 16'h0140, 16'h0000, 16'h0001, 16'h0001, 16'h0000, CHK_NONE, 0, 0, 0, 0},
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h5555, CHK_NONE, 0, 0, 0, 0},
    '{KIND_HEADER, 16'h0000, 16'h01E0, 16'h0001, 16'h0001, 16'h0000, CHK_NONE, 0, 0, 0, 0},
    '{KIND_HEADER, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, CHK_HDR, 0, 0, 0, 0},
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h6666, CHK_MODEL, 0, 0, 0, 0},
    '{KIND_HEADER, 16'h013E, 16'h01DE, 16'h8000, 16'h8000, 16'h0000, CHK_HDR, 318, 0, 478, 0},
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7777, CHK_NONE, 0, 0, 0, 0},
    '{KIND_HEADER, 16'h0136, 16'h01D6, 16'h7FFF, 16'h7FFF, 16'h0000, CHK_HDR, 310, 319, 470, 479},
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8888, CHK_PIX, 0, 0, 0, 0},
    '{KIND_HEADER, 16'h013F, 16'h01DF, 16'h0002, 16'h0001, 16'h0000, CHK_HDR, 319, 319, 479, 479},
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h9999, CHK_PIX, 0, 0, 0, 0},
    '{KIND_PIXEL,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hAAAA, CHK_NONE, 0, 0, 0, 0},
    '{KIND_HEADER, 16'h0000, 16'h0000, 16'h0000, 16'h0005, 16'h0000, CHK_HDR, 0, 0, 0, 4}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  in_mode_i = 1'b0;
  logic [FIELD_BITS-1:0] in_x_i = '0;
  logic [FIELD_BITS-1:0] in_y_i = '0;
  logic [FIELD_BITS-1:0] in_w_i = '0;
  logic [FIELD_BITS-1:0] in_h_i = '0;
  logic [FIELD_BITS-1:0] in_pixel_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  out_is_command_o;
  logic [FIELD_BITS-1:0] out_bus_value_o;
  logic                  out_last_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic                  cfg_index_i = 1'b0;
  logic [DIM_BITS-1:0]   cfg_wdata_i = '0;

  clipped_bitmap_blit_to_panel_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_mode_i        (in_mode_i),
    .in_x_i           (in_x_i),
    .in_y_i           (in_y_i),
    .in_w_i           (in_w_i),
    .in_h_i           (in_h_i),
    .in_pixel_i       (in_pixel_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_is_command_o (out_is_command_o),
    .out_bus_value_o  (out_bus_value_o),
    .out_last_o       (out_last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  int  panel_w = 320;
  int  panel_h = 480;
  bit  blit_open;
  int  org_col, org_row, span_w, span_h, cur_col, cur_row;

  write_t panel_writes_q [$];
  write_t step_writes_q [$];
  write_t want_w;

  int src_pct;
  int snk_pct;
  int err_count;
  int live_count;
  int cycle_cnt;

  task automatic report_mismatch(input string what, input logic [FIELD_BITS-1:0] got,
                                 input logic [FIELD_BITS-1:0] want);
    $display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic int clamp_dim(input int v, input int size);
    if (v < 0) return 0;
    if (v >= size) return size - 1;
    return v;
  endfunction

  task automatic push_corner(input int v);
    logic [FIELD_BITS-1:0] v16;
    v16 = FIELD_BITS'(v);
    step_writes_q.push_back('{1'b0, (v16 >> 8) & LOW_BYTE, 1'b0});
    step_writes_q.push_back('{1'b0, v16 & LOW_BYTE, 1'b0});
  endtask

  task automatic push_window(input int c0, input int c1, input int r0, input int r1);
    step_writes_q.push_back('{1'b1, CMD_COLUMN, 1'b0});
    push_corner(c0);
    push_corner(c1);
    step_writes_q.push_back('{1'b1, CMD_ROW, 1'b0});
    push_corner(r0);
    push_corner(r1);
    step_writes_q.push_back('{1'b1, CMD_MEMORY, 1'b1});
  endtask

  task automatic predict_panel_writes(input in_beat_t b);
    int x, y, w, h, px, py;
    step_writes_q.delete();
    if (b.mode == KIND_HEADER) begin
      x = int'($signed(b.x));
      y = int'($signed(b.y));
      w = int'($signed(b.w));
      h = int'($signed(b.h));
      blit_open = 1'b0;
      if (panel_w == 0 || panel_h == 0 || x >= panel_w || y >= panel_h) return;
      push_window(clamp_dim(x, panel_w), clamp_dim(x + w - 1, panel_w),
                  clamp_dim(y, panel_h), clamp_dim(y + h - 1, panel_h));
      org_col = x;
      org_row = y;
      span_w = w;
      span_h = h;
      cur_col = 0;
      cur_row = 0;
      blit_open = (w > 0 && h > 0);
    end else if (blit_open) begin
      px = org_col + cur_col;
      py = org_row + cur_row;
      if (px >= 0 && px < panel_w && py >= 0 && py < panel_h)
        step_writes_q.push_back('{1'b0, b.pixel, 1'b1});
      cur_col++;
      if (cur_col >= span_w) begin
        cur_col = 0;
        cur_row++;
        if (cur_row >= span_h) begin
          cur_row = 0;
          blit_open = 1'b0;
        end
      end
    end
  endtask

  // Drives one beat from the falling edge, returns at the accepting rising edge.
  task automatic send_beat(input in_beat_t b, input chk_e chk, input int c0, input int c1,
                           input int r0, input int r1);
    bit was_open;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_mode_i  <= b.mode;
    in_x_i     <= b.x;
    in_y_i     <= b.y;
    in_w_i     <= b.w;
    in_h_i     <= b.h;
    in_pixel_i <= b.pixel;
    do @(posedge clk_i); while (in_stall_o);
    was_open = blit_open;
    predict_panel_writes(b);
    case (chk)
      CHK_NONE: step_writes_q.delete();
      CHK_HDR: begin
        step_writes_q.delete();
        push_window(c0, c1, r0, r1);
      end
      CHK_PIX: begin
        step_writes_q.delete();
        step_writes_q.push_back('{1'b0, b.pixel, 1'b1});
      end
      default: ;
    endcase
    if (step_writes_q.size() > 0 || (b.mode == KIND_PIXEL && was_open)) live_count++;
    foreach (step_writes_q[i]) panel_writes_q.push_back(step_writes_q[i]);
  endtask

  task automatic park_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    while (panel_writes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_panel(input int wd, input int ht);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_WIDTH;
    cfg_wdata_i <= DIM_BITS'(wd);
    do @(posedge clk_i); while (!cfg_ready_o);
    panel_w = wd;
    @(negedge clk_i);
    cfg_index_i <= REG_HEIGHT;
    cfg_wdata_i <= DIM_BITS'(ht);
    do @(posedge clk_i); while (!cfg_ready_o);
    panel_h = ht;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int edge_coord(input int size);
    int base;
    base = $urandom_range(0, 1) ? 0 : size;
    return base + int'($urandom_range(0, 6)) - 4;
  endfunction

  task automatic random_segment(input int quota, input int max_tries);
    in_beat_t b;
    int tries, wi, hi, npix, pick;
    tries = 0;
    live_count = 0;
    while (live_count < quota && tries < max_tries) begin
      tries++;
      if ($urandom_range(0, 9) < 7) begin
        wi = $urandom_range(1, 4);
        hi = $urandom_range(1, 3);
        pick = $urandom_range(0, 9);
        if (pick == 0) wi = 32767;
        else if (pick == 1) hi = 0 - int'($urandom_range(0, 2));
        else if (pick == 2) wi = 0 - int'($urandom_range(0, 2));
        if (wi > 0 && hi > 0)
          npix = (wi > 8 || hi > 8) ? $urandom_range(1, 6) : wi * hi;
        else
          npix = $urandom_range(0, 2);
        // broken burst: restart before the bitmap ends
        if (npix > 0 && $urandom_range(0, 4) == 0) npix = $urandom_range(0, npix - 1);
        b = '{KIND_HEADER, FIELD_BITS'(edge_coord(panel_w)), FIELD_BITS'(edge_coord(panel_h)),
              FIELD_BITS'(wi), FIELD_BITS'(hi), FIELD_BITS'($urandom)};
        send_beat(b, CHK_MODEL, 0, 0, 0, 0);
        repeat (npix) begin
          b = '{KIND_PIXEL, FIELD_BITS'($urandom), FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                FIELD_BITS'($urandom), FIELD_BITS'($urandom)};
          send_beat(b, CHK_MODEL, 0, 0, 0, 0);
        end
      end else begin
        b = '{kind_e'($urandom_range(0, 1)), FIELD_BITS'($urandom), FIELD_BITS'($urandom),
              FIELD_BITS'($urandom), FIELD_BITS'($urandom), FIELD_BITS'($urandom)};
        send_beat(b, CHK_MODEL, 0, 0, 0, 0);
      end
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < snk_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (panel_writes_q.size() == 0) begin
        report_mismatch("beat with nothing pending", out_bus_value_o, '0);
      end else begin
        want_w = panel_writes_q.pop_front();
        if (out_is_command_o !== want_w.is_command)
          report_mismatch("is_command", 16'(out_is_command_o), 16'(want_w.is_command));
        if (out_bus_value_o !== want_w.bus_value)
          report_mismatch("bus_value", out_bus_value_o, want_w.bus_value);
        if (out_last_o !== want_w.last)
          report_mismatch("last", 16'(out_last_o), 16'(want_w.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    in_beat_t b;
    dir_row_t r;
    int seg;
    src_pct = 0;
    snk_pct = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_ROWS[i]) begin
      r = DIR_ROWS[i];
      b = '{r.mode, r.x, r.y, r.w, r.h, r.pixel};
      send_beat(b, r.chk, int'(r.c0), int'(r.c1), int'(r.r0), int'(r.r1));
    end
    park_input();
    wait_drain();

    for (seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin src_pct = 0;  snk_pct = 0;  end
        1: begin src_pct = 56; snk_pct = 0;  end
        2: begin src_pct = 0;  snk_pct = 56; end
        default: begin src_pct = 31; snk_pct = 31; end
      endcase
      case (seg)
        0: set_panel(4095, 4095);
        1: set_panel(1, 1);
        2: set_panel(0, $urandom_range(1, 4095));
        3: set_panel($urandom_range(2, 24), $urandom_range(2, 24));
        4: set_panel($urandom_range(1, 4095), 0);
        5: set_panel($urandom_range(2, 24), $urandom_range(2, 24));
        6: set_panel(320, 480);
        default: set_panel($urandom_range(1, 4095), $urandom_range(1, 4095));
      endcase
      if (panel_w == 0 || panel_h == 0) random_segment(8, 3);
      else random_segment(8, 60);
      park_input();
      wait_drain();
    end

    if (err_count == 0 && panel_writes_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
